FILE: rtl/sorted_insert_priority_queue_assert.svh
// Assertion macros for the sorted insert priority queue.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge outside reset.
`define SIPQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SIPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SIPQ_ASSERT_SAME(lbl, ante, cons, msg)
`define SIPQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/sipq_pkg.sv
// Shared types and constants for the sorted insert priority queue.
// No dependencies; imported by the cell and the top level.
package sipq_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OCC_W    = 5;
    localparam int STATUS_W = 2;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Command broadcast to every cell of the chain at once.
    typedef struct packed
    {
        logic                     insert_en;
        logic                     remove_en;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

FILE: rtl/sipq_cell.sv
// One storage cell of the sorted chain: holds a single entry.
// Depends on sipq_pkg for the command struct and data width.
module sipq_cell
    import sipq_pkg::*;
(
    input  logic                     clk,
    input  cell_cmd_t                cmd,
    input  logic                     valid,
    input  logic                     left_gt,
    input  logic signed [DATA_W-1:0] left_entry,
    input  logic signed [DATA_W-1:0] right_entry,
    output logic                     gt,
    output logic signed [DATA_W-1:0] entry
);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;

    // An empty cell counts as greater, so the new value lands at the tail.
    assign gt = !valid || (entry_reg > cmd.value);

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.insert_en && gt)
        begin
            // The first greater cell takes the new value; the ones after it shift right.
            entry_next = left_gt ? left_entry : cmd.value;
        end
        else if (cmd.remove_en)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

FILE: rtl/sorted_insert_priority_queue.sv
// Top level of the sorted insert priority queue: a chain of sipq_cell instances
// plus the entry count and the output register. Depends on sipq_pkg and the assert header.
//
//   Channel | Handshake           | Fields
//   --------+---------------------+-------------------------------------------
//   input   | in_valid / in_ready | operation (1), value (32, signed)
//   output  | out_valid/out_ready | status (2), removed_value (32, signed),
//           |                     | occupancy (5)
//
// Every beat is finished in the cycle it is accepted: all cells compare against
// the incoming value in parallel and shift together, so one item per cycle unless
// the output stalls. The result sits in an output register; a new beat is taken
// whenever that register is empty or is being drained in the same cycle.
// Reset clears the entry count and the output valid; cell contents are not reset,
// because only cells below the count are ever read.
`include "sorted_insert_priority_queue_assert.svh"

module sorted_insert_priority_queue
    import sipq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     operation,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic signed [DATA_W-1:0] removed_value,
    output logic [OCC_W-1:0]         occupancy
);

    // Entry count and output register.
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic signed [DATA_W-1:0] removed_reg;
    logic signed [DATA_W-1:0] removed_next;
    logic [OCC_W-1:0]         occ_reg;
    logic [OCC_W-1:0]         occ_next;

    logic      accept;
    logic      full;
    logic      empty;
    op_t       op;
    cell_cmd_t cmd;

    logic                     cell_gt    [CAPACITY];
    logic signed [DATA_W-1:0] cell_entry [CAPACITY];

    // The output register can take a new result when it is empty or being read.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign op    = op_t'(operation);
    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    // A remove on an empty list and an insert on a full list leave the chain alone.
    assign cmd.insert_en = accept && (op == OP_INSERT) && !full;
    assign cmd.remove_en = accept && (op == OP_REMOVE) && !empty;
    assign cmd.value     = value;

    // The chain. Cell 0 holds the smallest entry. Each cell sees its left
    // neighbor (for the right shift of an insert) and its right neighbor
    // (for the left shift of a remove). The last cell simply keeps its own
    // value on a remove, since it falls outside the count afterward.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                     left_gt;
        logic signed [DATA_W-1:0] left_entry;
        logic signed [DATA_W-1:0] right_entry;

        if (i == 0)
        begin : g_head
            assign left_gt    = 1'b0;
            assign left_entry = value;
        end
        else
        begin : g_body
            assign left_gt    = cell_gt[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_mid
            assign right_entry = cell_entry[i+1];
        end

        sipq_cell u_cell
        (
            .clk         (clk),
            .cmd         (cmd),
            .valid       (count_reg > CNT_W'(i)),
            .left_gt     (left_gt),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .gt          (cell_gt[i]),
            .entry       (cell_entry[i])
        );
    end

    // Count and result for the beat being accepted.
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        removed_next   = removed_reg;
        occ_next       = occ_reg;

        if (cmd.insert_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.remove_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        if (accept)
        begin
            out_valid_next = 1'b1;
            removed_next   = cmd.remove_en ? cell_entry[0] : '0;
            occ_next       = OCC_W'(count_next);
            unique case (op)
                OP_INSERT: status_next = full  ? ST_FULL  : ST_OK;
                OP_REMOVE: status_next = empty ? ST_EMPTY : ST_OK;
                default:   status_next = ST_OK;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload needs no reset; it is only looked at behind out_valid.
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        removed_reg <= removed_next;
        occ_reg     <= occ_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign occupancy     = occ_reg;

    // The count never runs past the capacity of the chain.
    `SIPQ_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "count above capacity")

    // A successful insert grows the count by exactly one.
    `SIPQ_ASSERT_NEXT(a_insert_count, cmd.insert_en, count_reg == $past(count_reg) + CNT_W'(1), "insert count step wrong")

    // A successful remove returns what was at the head of the chain.
    `SIPQ_ASSERT_NEXT(a_remove_head, cmd.remove_en, removed_reg == $past(cell_entry[0]), "removed value is not the head")

    // A dropped insert is only reported when the chain is full.
    `SIPQ_ASSERT_SAME(a_full_occ, out_valid_reg && (status_reg == ST_FULL), occ_reg == OCC_W'(CAPACITY), "full status with room left")

endmodule
